// File: rtl/core/hdep_pkg.sv
// ----------------------------------------------------------------------------
// hdep_pkg
// Shared types and constants of the HTTP date to epoch parser.
// ----------------------------------------------------------------------------
package hdep_pkg;

    localparam int FIELD_W = 14;
    localparam int EPOCH_W = 35;
    localparam int TDATA_OUT_W = 40;

    localparam logic [FIELD_W-1:0] NUM_MAX = 14'd16383;

    // One parsed header, handed from the parser to the converter.
    typedef struct packed {
        logic               done;
        logic [3:0]         month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] year;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
    } hdep_entry_t;

    typedef struct packed {
        logic        push;
        hdep_entry_t entry;
    } hdep_qwr_t;

    typedef struct packed {
        logic        valid;
        hdep_entry_t entry;
    } hdep_qrd_t;

endpackage

// File: rtl/core/hdep_front.sv
// ----------------------------------------------------------------------------
// hdep_front
// Byte-wise date header parser; pushes one parsed record per header.
// ----------------------------------------------------------------------------
module hdep_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output hdep_pkg::hdep_qwr_t q_wr
);

    typedef enum logic [3:0] {
        PH_SKIP_FIRST, PH_SKIP_REST, PH_DAY_PRE, PH_DAY_NUM,
        PH_MON_PRE, PH_MON_IN, PH_YEAR_PRE, PH_YEAR_NUM,
        PH_HOUR_PRE, PH_HOUR_NUM, PH_MIN_PRE, PH_MIN_NUM,
        PH_SEC_PRE, PH_SEC_NUM, PH_DONE, PH_FAIL
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;

    localparam int FW = hdep_pkg::FIELD_W;

    function automatic logic [3:0] month_of(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2);
        logic [23:0] s;
        logic [3:0]  m;
        s = {c0, c1, c2};
        m = 4'd0;
        unique case (s)
            "Jan": m = 4'd1;
            "Feb": m = 4'd2;
            "Mar": m = 4'd3;
            "Apr": m = 4'd4;
            "May": m = 4'd5;
            "Jun": m = 4'd6;
            "Jul": m = 4'd7;
            "Aug": m = 4'd8;
            "Sep": m = 4'd9;
            "Oct": m = 4'd10;
            "Nov": m = 4'd11;
            "Dec": m = 4'd12;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

    phase_t        phase_reg, phase_next;
    logic          sign_reg, sign_next;
    logic [FW-1:0] value_reg, value_next;
    logic          seen_reg, seen_next;
    logic [7:0]    chars_reg [3];
    logic [7:0]    chars_next [3];
    logic [1:0]    count_reg, count_next;
    logic [FW-1:0] day_reg, day_next;
    logic [FW-1:0] year_reg, year_next;
    logic [FW-1:0] hour_reg, hour_next;
    logic [FW-1:0] minute_reg, minute_next;
    logic [FW-1:0] second_reg, second_next;
    logic          bad_reg, bad_next;
    logic          ended_reg, ended_next;

    logic          is_ws, is_digit, is_nul;
    logic [3:0]    digit_val;
    logic [17:0]   acc_wide;
    logic [FW-1:0] acc_sat;
    logic          take_bad;
    logic          do_start, do_month;
    phase_t        start_pre;
    logic [3:0]    month_num;

    assign is_nul    = (in_byte == CH_NUL);
    assign is_ws     = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
    assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit_val = 4'(in_byte - CH_ZERO);
    assign acc_wide  = 18'(value_reg) * 18'd10 + 18'(digit_val);
    assign acc_sat   = (acc_wide > 18'(hdep_pkg::NUM_MAX)) ? hdep_pkg::NUM_MAX
                                                            : acc_wide[FW-1:0];
    assign take_bad  = sign_reg && (value_reg != '0);
    assign month_num = (count_reg == 2'd3) ? month_of(chars_reg[0], chars_reg[1], chars_reg[2])
                                           : 4'd0;

    always_comb begin
        phase_next  = phase_reg;
        sign_next   = sign_reg;
        value_next  = value_reg;
        seen_next   = seen_reg;
        chars_next  = chars_reg;
        count_next  = count_reg;
        day_next    = day_reg;
        year_next   = year_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        bad_next    = bad_reg;
        ended_next  = ended_reg;
        do_start    = 1'b0;
        do_month    = 1'b0;
        start_pre   = phase_reg;
        q_wr        = '0;

        if (in_accept && !ended_reg) begin
            if (!is_nul) begin
                unique case (phase_reg)
                    PH_SKIP_FIRST: begin
                        phase_next = (in_byte == CH_COMMA) ? PH_FAIL : PH_SKIP_REST;
                    end
                    PH_SKIP_REST: begin
                        if (in_byte == CH_COMMA) phase_next = PH_DAY_PRE;
                    end
                    PH_DAY_PRE, PH_YEAR_PRE, PH_HOUR_PRE, PH_MIN_PRE, PH_SEC_PRE: begin
                        do_start  = 1'b1;
                        start_pre = phase_reg;
                    end
                    PH_MON_PRE: begin
                        if (!is_ws) do_month = 1'b1;
                    end
                    PH_MON_IN: begin
                        if (is_ws) phase_next = PH_YEAR_PRE;
                        else do_month = 1'b1;
                    end
                    PH_DAY_NUM, PH_YEAR_NUM, PH_HOUR_NUM, PH_MIN_NUM, PH_SEC_NUM: begin
                        if (is_digit) begin
                            value_next = acc_sat;
                            seen_next  = 1'b1;
                        end else if (!seen_reg) begin
                            phase_next = PH_FAIL;
                        end else begin
                            bad_next = bad_reg | take_bad;
                            unique case (phase_reg)
                                PH_DAY_NUM: begin
                                    day_next   = value_reg;
                                    phase_next = PH_MON_PRE;
                                    if (!is_ws) do_month = 1'b1;
                                end
                                PH_YEAR_NUM: begin
                                    year_next = value_reg;
                                    do_start  = 1'b1;
                                    start_pre = PH_HOUR_PRE;
                                end
                                PH_HOUR_NUM: begin
                                    hour_next  = value_reg;
                                    phase_next = (in_byte == CH_COLON) ? PH_MIN_PRE : PH_FAIL;
                                end
                                PH_MIN_NUM: begin
                                    minute_next = value_reg;
                                    phase_next  = (in_byte == CH_COLON) ? PH_SEC_PRE : PH_FAIL;
                                end
                                default: begin
                                    second_next = value_reg;
                                    phase_next  = PH_DONE;
                                end
                            endcase
                        end
                    end
                    PH_DONE, PH_FAIL: begin
                    end
                endcase

                if (do_start) begin
                    value_next = is_digit ? FW'(digit_val) : '0;
                    sign_next  = (in_byte == CH_MINUS);
                    seen_next  = is_digit;
                    if (is_ws) begin
                        phase_next = start_pre;
                    end else if (is_digit || in_byte == CH_PLUS || in_byte == CH_MINUS) begin
                        phase_next = phase_t'(start_pre + 4'd1);
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end

                if (do_month) begin
                    if (count_reg != 2'd3) chars_next[count_reg] = in_byte;
                    count_next = count_reg + 2'd1;
                    phase_next = (count_reg == 2'd2) ? PH_YEAR_PRE : PH_MON_IN;
                end
            end

            // end of text: a pending second is taken, anything else unfinished fails
            if (is_nul || in_last) begin
                if (phase_next == PH_SEC_NUM && seen_next) begin
                    second_next = value_next;
                    if (sign_next && value_next != '0) bad_next = 1'b1;
                    phase_next = PH_DONE;
                end else if (phase_next != PH_DONE) begin
                    phase_next = PH_FAIL;
                end
                ended_next = 1'b1;
            end
        end

        if (in_accept && in_last) begin
            q_wr.push         = 1'b1;
            q_wr.entry.done   = (phase_next == PH_DONE) && !bad_next && (month_num != 4'd0);
            q_wr.entry.month  = month_num;
            q_wr.entry.day    = day_next;
            q_wr.entry.year   = year_next;
            q_wr.entry.hour   = hour_next;
            q_wr.entry.minute = minute_next;
            q_wr.entry.second = second_next;

            phase_next  = PH_SKIP_FIRST;
            sign_next   = 1'b0;
            value_next  = '0;
            seen_next   = 1'b0;
            chars_next  = '{default: 8'd0};
            count_next  = 2'd0;
            day_next    = '0;
            year_next   = '0;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            bad_next    = 1'b0;
            ended_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP_FIRST;
            sign_reg   <= 1'b0;
            value_reg  <= '0;
            seen_reg   <= 1'b0;
            chars_reg  <= '{default: 8'd0};
            count_reg  <= 2'd0;
            day_reg    <= '0;
            year_reg   <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            bad_reg    <= 1'b0;
            ended_reg  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            sign_reg   <= sign_next;
            value_reg  <= value_next;
            seen_reg   <= seen_next;
            chars_reg  <= chars_next;
            count_reg  <= count_next;
            day_reg    <= day_next;
            year_reg   <= year_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            bad_reg    <= bad_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

// File: rtl/core/hdep_queue.sv
// ----------------------------------------------------------------------------
// hdep_queue
// Two-entry FIFO of parsed header records between parser and converter.
// ----------------------------------------------------------------------------
module hdep_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  hdep_pkg::hdep_qwr_t q_wr,
    input  logic                q_pop,
    output hdep_pkg::hdep_qrd_t q_rd,
    output logic                q_full
);

    hdep_pkg::hdep_entry_t mem_reg [2];
    logic                  wr_ptr_reg, rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  do_push, do_pop;

    assign q_full     = (count_reg == 2'd2);
    assign q_rd.valid = (count_reg != 2'd0);
    assign q_rd.entry = mem_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && q_rd.valid;

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= q_wr.entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// File: rtl/core/hdep_back.sv
// ----------------------------------------------------------------------------
// hdep_back
// Range checks and days-from-civil conversion, one record at a time.
// ----------------------------------------------------------------------------
module hdep_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hdep_pkg::hdep_qrd_t                  q_rd,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [hdep_pkg::EPOCH_W-1:0]         out_epoch,
    output logic                                 out_ok
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_ERA, ST_YOE, ST_DOE, ST_DAYS, ST_MUL, ST_SUM
    } state_t;

    localparam int EW = hdep_pkg::EPOCH_W;

    // day of year of the first of each month in a March-based year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    state_t         state_reg;
    logic           ok_reg;
    logic [11:0]    y_reg;
    logic [8:0]     doy_reg;
    logic [4:0]     hour_reg;
    logic [5:0]     minute_reg;
    logic [5:0]     second_reg;
    logic [16:0]    hms_reg;
    logic [2:0]     era_reg;
    logic [8:0]     yoe_reg;
    logic [17:0]    doe_reg;
    logic [18:0]    days_reg;
    logic [EW-1:0]  prod_reg;
    logic           out_valid_reg;
    logic [EW-1:0]  out_epoch_reg;
    logic           out_ok_reg;

    hdep_pkg::hdep_entry_t e;
    logic           check_ok;
    logic [27:0]    era_prod;
    logic [11:0]    yoe_full;
    logic [13:0]    q100_prod;
    logic [20:0]    days_full;

    assign e = q_rd.entry;
    assign check_ok = e.done &&
                      e.day >= 14'd1 && e.day <= 14'd31 &&
                      e.year >= 14'd1970 && e.year <= 14'd2999 &&
                      e.hour <= 14'd23 && e.minute <= 14'd59 && e.second <= 14'd60;

    assign era_prod  = 28'(y_reg) * 28'd41944;
    assign yoe_full  = y_reg - 12'(era_reg) * 12'd400;
    assign q100_prod = 14'(yoe_reg) * 14'd41;
    assign days_full = 21'(era_reg) * 21'd146097 + 21'(doe_reg) - 21'd719468;

    assign q_pop     = (state_reg == ST_IDLE) && q_rd.valid;
    assign out_valid = out_valid_reg;
    assign out_epoch = out_epoch_reg;
    assign out_ok    = out_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_rd.valid) begin
                        ok_reg     <= check_ok;
                        y_reg      <= e.year[11:0] - 12'(e.month <= 4'd2);
                        doy_reg    <= month_start(e.month) + 9'(e.day[4:0]) - 9'd1;
                        hour_reg   <= e.hour[4:0];
                        minute_reg <= e.minute[5:0];
                        second_reg <= e.second[5:0];
                        state_reg  <= ST_ERA;
                    end
                end
                ST_ERA: begin
                    era_reg   <= era_prod[26:24];
                    hms_reg   <= 17'(hour_reg) * 17'd3600 + 17'(minute_reg) * 17'd60 +
                                 17'(second_reg);
                    state_reg <= ST_YOE;
                end
                ST_YOE: begin
                    yoe_reg   <= yoe_full[8:0];
                    state_reg <= ST_DOE;
                end
                ST_DOE: begin
                    doe_reg   <= 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) -
                                 18'(q100_prod[13:12]) + 18'(doy_reg);
                    state_reg <= ST_DAYS;
                end
                ST_DAYS: begin
                    days_reg  <= days_full[18:0];
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= EW'(days_reg) * EW'(86400);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    if (!out_valid_reg || out_ready) begin
                        out_epoch_reg <= ok_reg ? prod_reg + EW'(hms_reg) : '0;
                        out_ok_reg    <= ok_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/http_date_to_epoch_parser.sv
// Parses an HTTP Date header ("Sun, 06 Nov 1994 08:49:37 GMT") arriving as a
// byte stream and returns one transaction per header on the byte marked tlast:
// seconds since 1970-01-01 UTC, with date_ok in tuser (epoch 0 when not ok).
// Header bytes are taken at one per cycle while s_tready is high. After the last
// byte the record waits in a two-entry queue, then passes the converter states
// (era, yoe, doe, days, mul, sum) and a result register that waits on m_tready;
// s_tready drops only while two headers are queued.
// ----------------------------------------------------------------------------
// http_date_to_epoch_parser
// Top level: byte parser, record queue and epoch converter.
// ----------------------------------------------------------------------------
module http_date_to_epoch_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] header_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [34:0] epoch_seconds, [39:35] zero
    output logic [0:0]  m_tuser    // [0] date_ok
);

    hdep_pkg::hdep_qwr_t           q_wr;
    hdep_pkg::hdep_qrd_t           q_rd;
    logic                          q_pop;
    logic                          q_full;
    logic [hdep_pkg::EPOCH_W-1:0]  epoch;
    logic                          ok;

    assign s_tready = !q_full;

    hdep_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_wr      (q_wr)
    );

    hdep_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_pop   (q_pop),
        .q_rd    (q_rd),
        .q_full  (q_full)
    );

    hdep_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd      (q_rd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_epoch (epoch),
        .out_ok    (ok)
    );

    assign m_tdata = {(hdep_pkg::TDATA_OUT_W - hdep_pkg::EPOCH_W)'(0), epoch};
    assign m_tuser = ok;

endmodule

// File: rtl/core/hdep_checker.sv
// ----------------------------------------------------------------------------
// hdep_checker
// Port-level checks of the HTTP date to epoch parser.
// ----------------------------------------------------------------------------
module hdep_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 40'd0))
        else $error("failed date with nonzero epoch");

    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata >= 40'd0 && m_tdata <= 40'd32503680000))
        else $error("epoch out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tlast)))
        else $error("stalled input transaction changed");

endmodule

bind http_date_to_epoch_parser hdep_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and checking for http_date_to_epoch_parser. Header text goes in as
// byte transactions; a byte-level model of the date scanner predicts the epoch
// and date_ok of every header, and each result transaction is compared with it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_BYTES = 1150;
    localparam logic [8*36-1:0] MONTH_NAMES = "JanFebMarAprMayJunJulAugSepOctNovDec";

    typedef enum logic [3:0] {
        P_LEAD, P_LEAD_MORE, P_DAY_WS, P_DAY, P_MON_WS, P_MON, P_YEAR_WS, P_YEAR,
        P_HOUR_WS, P_HOUR, P_MIN_WS, P_MIN, P_SEC_WS, P_SEC, P_END, P_BAD
    } date_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } hdr_byte_t;

    typedef struct packed {
        logic [hdep_pkg::EPOCH_W-1:0] epoch;
        logic                         ok;
    } date_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    hdr_byte_t    header_bytes[$];
    logic [7:0]   hdr[$];
    date_result_t expected_dates[$];
    hdr_byte_t    next_byte;
    date_result_t want;

    int unsigned n_items = 0;
    int unsigned sent_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;

    // scanner state
    date_phase_t                  sc_phase;
    logic                         sc_neg;
    logic [hdep_pkg::FIELD_W-1:0] sc_num;
    logic                         sc_any;
    logic [7:0]                   sc_mon[3];
    int unsigned                  sc_mon_cnt;
    logic [hdep_pkg::FIELD_W-1:0] f_day, f_year, f_hour, f_min, f_sec;
    logic                         f_neg_bad;
    logic                         f_ended;

    always #10 aclk = ~aclk;

    http_date_to_epoch_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic logic [7:0] mon_byte(input int unsigned k);
        return MONTH_NAMES[8*(35-k) +: 8];
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void scan_reset();
        sc_phase = P_LEAD;
        sc_neg = 1'b0;
        sc_num = '0;
        sc_any = 1'b0;
        sc_mon[0] = '0;
        sc_mon[1] = '0;
        sc_mon[2] = '0;
        sc_mon_cnt = 0;
        f_day = '0;
        f_year = '0;
        f_hour = '0;
        f_min = '0;
        f_sec = '0;
        f_neg_bad = 1'b0;
        f_ended = 1'b0;
    endfunction

    function automatic void add_dig(input logic [7:0] c);
        int unsigned v;
        v = int'(sc_num) * 10 + int'(c) - 48;
        sc_num = (v > hdep_pkg::NUM_MAX) ? hdep_pkg::NUM_MAX : v[hdep_pkg::FIELD_W-1:0];
        sc_any = 1'b1;
    endfunction

    function automatic logic [hdep_pkg::FIELD_W-1:0] take_num();
        if (sc_neg && sc_num != 0) f_neg_bad = 1'b1;
        return sc_num;
    endfunction

    // whitespace ahead of a number; the number phase follows its pre phase
    function automatic void num_start(input logic [7:0] c);
        sc_num = '0;
        sc_neg = 1'b0;
        sc_any = 1'b0;
        if (is_space(c)) begin
            return;
        end
        if (c == "+") begin
            sc_phase = date_phase_t'(sc_phase + 4'd1);
        end else if (c == "-") begin
            sc_neg = 1'b1;
            sc_phase = date_phase_t'(sc_phase + 4'd1);
        end else if (is_dig(c)) begin
            add_dig(c);
            sc_phase = date_phase_t'(sc_phase + 4'd1);
        end else begin
            sc_phase = P_BAD;
        end
    endfunction

    function automatic void mon_char(input logic [7:0] c);
        if (sc_mon_cnt < 3) sc_mon[sc_mon_cnt] = c;
        sc_mon_cnt++;
        sc_phase = (sc_mon_cnt >= 3) ? P_YEAR_WS : P_MON;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        bit again;
        again = 1'b1;
        for (int pass = 0; pass < 2 && again; pass++) begin
            again = 1'b0;
            case (sc_phase)
                P_LEAD: sc_phase = (c == ",") ? P_BAD : P_LEAD_MORE;
                P_LEAD_MORE: if (c == ",") sc_phase = P_DAY_WS;
                P_DAY_WS, P_YEAR_WS, P_HOUR_WS, P_MIN_WS, P_SEC_WS: num_start(c);
                P_MON_WS: if (!is_space(c)) mon_char(c);
                P_MON: begin
                    if (is_space(c)) sc_phase = P_YEAR_WS;
                    else mon_char(c);
                end
                P_DAY, P_YEAR, P_HOUR, P_MIN, P_SEC: begin
                    if (is_dig(c)) begin
                        add_dig(c);
                    end else if (!sc_any) begin
                        sc_phase = P_BAD;
                    end else begin
                        case (sc_phase)
                            P_DAY: begin
                                f_day = take_num();
                                sc_phase = P_MON_WS;
                                again = 1'b1;
                            end
                            P_YEAR: begin
                                f_year = take_num();
                                sc_phase = P_HOUR_WS;
                                again = 1'b1;
                            end
                            P_HOUR: begin
                                f_hour = take_num();
                                sc_phase = (c == ":") ? P_MIN_WS : P_BAD;
                            end
                            P_MIN: begin
                                f_min = take_num();
                                sc_phase = (c == ":") ? P_SEC_WS : P_BAD;
                            end
                            default: begin
                                f_sec = take_num();
                                sc_phase = P_END;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void end_text();
        if (sc_phase == P_SEC && sc_any) begin
            f_sec = take_num();
            sc_phase = P_END;
        end else if (sc_phase != P_END) begin
            sc_phase = P_BAD;
        end
        f_ended = 1'b1;
    endfunction

    function automatic int unsigned month_index();
        if (sc_mon_cnt != 3) return 0;
        for (int unsigned i = 0; i < 12; i++) begin
            if (sc_mon[0] == mon_byte(3*i) && sc_mon[1] == mon_byte(3*i+1) &&
                sc_mon[2] == mon_byte(3*i+2)) return i + 1;
        end
        return 0;
    endfunction

    // one header byte; on the last byte the epoch is predicted and queued
    function automatic void date_step(input logic [7:0] c, input logic lst);
        longint y, era, yoe, mp, doy, doe, days, ep;
        int unsigned m;
        logic ok;
        if (!f_ended) begin
            if (c == 8'd0) end_text();
            else scan_char(c);
        end
        if (!lst) return;
        if (!f_ended) end_text();
        m = month_index();
        ep = 0;
        ok = 1'b0;
        if (sc_phase == P_END && m != 0 && !f_neg_bad && f_day >= 1 && f_day <= 31 &&
            f_year >= 1970 && f_year <= 2999 && f_hour <= 23 && f_min <= 59 &&
            f_sec <= 60) begin
            y = longint'(f_year) - ((m <= 2) ? 1 : 0);
            era = y / 400;
            yoe = y - era * 400;
            mp = longint'((m > 2) ? m - 3 : m + 9);
            doy = (153 * mp + 2) / 5 + longint'(f_day) - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * 146097 + doe - 719468;
            ep = days * 86400 + longint'(f_hour) * 3600 + longint'(f_min) * 60 +
                 longint'(f_sec);
            ok = 1'b1;
        end
        expected_dates.push_back('{epoch: ep[hdep_pkg::EPOCH_W-1:0], ok: ok});
        scan_reset();
    endfunction

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
    endtask

    task automatic add_ws(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        repeat ($urandom_range(hi, lo)) begin
            r = $urandom_range(7);
            hdr.push_back((r < 5) ? 8'd9 + r[7:0] : 8'd32);
        end
    endtask

    task automatic add_field(input int unsigned lo, input int unsigned hi);
        int unsigned v, r;
        r = $urandom_range(99);
        if (r < 88) v = $urandom_range(hi, lo);
        else if (r < 97) v = $urandom_range(hi + hi / 4 + 2, 0);
        else v = $urandom_range(2000000, 10000);
        r = $urandom_range(99);
        if (r < 3) hdr.push_back("-");
        else if (r < 6) hdr.push_back("+");
        add_str(($urandom_range(3) == 0) ? $sformatf("%04d", v) : $sformatf("%0d", v));
    endtask

    task automatic commit_header();
        for (int i = 0; i < hdr.size(); i++) begin
            header_bytes.push_back('{ch: hdr[i], lst: (i == hdr.size() - 1)});
        end
        hdr.delete();
    endtask

    task automatic send_header(input string s);
        add_str(s);
        commit_header();
    endtask

    function automatic int unsigned idle_pct(input bit rx_side);
        if (sent_cnt < n_items / 3) return rx_side ? 81 : 37;
        if (sent_cnt < 2 * n_items / 3) return rx_side ? 37 : 81;
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                date_step(s_tdata, s_tlast);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (header_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    next_byte = header_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.ch;
                    s_tlast <= next_byte.lst;
                    sent_cnt++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_dates.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result transaction, epoch=%0d ok=%0b", $time,
                             m_tdata[hdep_pkg::EPOCH_W-1:0], m_tuser[0]);
                end else begin
                    want = expected_dates.pop_front();
                    if (m_tdata[hdep_pkg::EPOCH_W-1:0] !== want.epoch ||
                        m_tdata[39:hdep_pkg::EPOCH_W] !== '0) begin
                        mismatch_cnt++;
                        $display("%0t: epoch expected %0d, actual %0d (tdata %h)", $time,
                                 want.epoch, m_tdata[hdep_pkg::EPOCH_W-1:0], m_tdata);
                    end
                    if (m_tuser[0] !== want.ok) begin
                        mismatch_cnt++;
                        $display("%0t: date_ok expected %0b, actual %0b", $time,
                                 want.ok, m_tuser[0]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned n_dir, kind, r, k, n_mon, pos;
        logic [7:0] mon[3];
        logic [7:0] b;
        scan_reset();

        // directed headers
        send_header("Sun, 06 Nov 1994 08:49:37 GMT");
        send_header("Thu, 01 Jan 1970 00:00:00 GMT");
        send_header("Tue, 31 Dec 2999 23:59:60 GMT");
        send_header("Mon,\t+1  Feb 2000 -0:+5:-0");
        send_header("Mon, -1 Mar 2000 10:00:00");
        send_header("Fri, 99999 Jan 2020 00:00:00");
        send_header("Fri, 1 Jan 99999999 00:00:00");
        send_header("Sat, 31 Feb 2021 12:00:00");
        send_header("Wed, 29 Feb 2024 1:2:3");
        send_header("Sun, 06 Nov 1994 08:49:37");
        send_header(", 06 Nov 1994 08:49:37 GMT");
        send_header("Sun 06 Nov 1994 08:49:37 GMT");
        send_header("Sun, 06 Nov 1994 08-49-37");
        send_header("Sun, 06 nov 1994 08:49:37");
        send_header("Sun, 06 No 1994 08:49:37");
        send_header("Sun, 06 Novem 1994 08:49:37");
        send_header("x,32 Jan 1970 0:0:0");
        send_header("x, 1 Jan 1969 0:0:0");
        send_header("x,1 Jan 3000 24:60:61");
        add_str("Sun, 06 Nov 1994 08:49:37");
        hdr.push_back(8'h00);
        add_str(", 1 Jan 2000 0:0:0");
        commit_header();
        hdr.push_back(8'hFF);
        hdr.push_back(8'h80);
        add_str(", 01 Jan 1970 00:00:00 GMT");
        commit_header();
        hdr.push_back(8'h00);
        commit_header();
        hdr.push_back(8'hFF);
        commit_header();
        n_dir = header_bytes.size();

        while (header_bytes.size() < n_dir + RANDOM_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                repeat ($urandom_range(24, 1)) begin
                    r = $urandom_range(99);
                    if (r < 10) hdr.push_back(",");
                    else if (r < 20) hdr.push_back(":");
                    else if (r < 30) hdr.push_back(8'("0" + $urandom_range(9)));
                    else hdr.push_back(8'($urandom_range(255)));
                end
            end else begin
                if ($urandom_range(99) < 60) begin
                    add_str("Sun");
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        b = 8'($urandom_range(255, 1));
                        hdr.push_back((b == ",") ? "a" : b);
                    end
                end
                hdr.push_back(",");
                add_ws(0, 2);
                add_field(1, 31);
                add_ws(0, 2);
                k = $urandom_range(11);
                for (int j = 0; j < 3; j++) mon[j] = mon_byte(3*k + j);
                r = $urandom_range(99);
                if (r >= 90 && r < 95) begin
                    pos = $urandom_range(2);
                    mon[pos] = mon[pos] ^ 8'h20;
                end
                n_mon = (r >= 98) ? 4 : (r >= 95) ? 2 : 3;
                for (int j = 0; j < n_mon; j++) hdr.push_back((j < 3) ? mon[j] : "x");
                add_ws(1, 2);
                add_field(1970, 2999);
                add_ws(1, 2);
                add_field(0, 23);
                hdr.push_back(":");
                add_ws(0, 1);
                add_field(0, 59);
                hdr.push_back(":");
                add_field(0, 60);
                r = $urandom_range(99);
                if (r >= 40 && r < 80) begin
                    add_str(" GMT");
                end else if (r >= 80) begin
                    hdr.push_back(8'h00);
                    repeat ($urandom_range(4)) hdr.push_back(8'($urandom_range(255)));
                end
                if (kind >= 90) begin
                    pos = $urandom_range(hdr.size() - 1);
                    if ($urandom_range(1) == 0) begin
                        hdr[pos] = 8'($urandom_range(255));
                    end else begin
                        while (hdr.size() > pos + 1) void'(hdr.pop_back());
                    end
                end
            end
            commit_header();
        end
        n_items = header_bytes.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < n_items) @(posedge aclk);
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
